// ===== rtl/core/prq_pkg.sv =====
`timescale 1ns / 1ps

package prq_pkg;

    localparam int unsigned QueueDepth = 16;

    localparam logic [2:0] MODE_SUBMIT = 3'd0;
    localparam logic [2:0] MODE_POP    = 3'd1;
    localparam logic [2:0] MODE_PEEK   = 3'd2;
    localparam logic [2:0] MODE_CANCEL = 3'd3;
    localparam logic [2:0] MODE_FLUSH  = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_NONE  = 2'd3;

    // Stored entry: id, payload and packed tag fields.
    typedef struct packed {
        logic [31:0] id;
        logic [31:0] buffer;
        logic [31:0] frame;
        logic [63:0] deadline;
        logic [3:0]  display;
        logic [2:0]  layer;
        logic [1:0]  prio;
        logic        skip;
        logic        imm;
        logic        cancelled;
    } t_entry;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the input item
        logic scan;      // examine entry at scan index, advance index
        logic shift;     // perform one shift step
        logic finish;    // apply final write and count update
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;
        logic shift_done;
    } t_sts;

endpackage

// ===== rtl/core/prq_ctrl.sv =====
`timescale 1ns / 1ps

module prq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  prq_pkg::t_sts   i_sts,
    output prq_pkg::t_cmd   o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_SHIFT = 3'd2;
    localparam logic [2:0] S_FIN   = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0] r_state, n_state;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) n_state = S_SHIFT;
            end
            S_SHIFT: begin
                o_cmd.shift = 1'b1;
                if (i_sts.shift_done) n_state = S_FIN;
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

endmodule

// ===== rtl/core/prq_dp.sv =====
`timescale 1ns / 1ps

module prq_dp #(
    parameter int unsigned QUEUE_DEPTH = prq_pkg::QueueDepth
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  prq_pkg::t_cmd   i_cmd,
    output prq_pkg::t_sts   o_sts,
    input  logic [2:0]      i_mode,
    input  logic [3:0]      i_display_index,
    input  logic [2:0]      i_layer_index,
    input  logic [31:0]     i_buffer_handle,
    input  logic [1:0]      i_prio_level,
    input  logic [31:0]     i_frame_number,
    input  logic [63:0]     i_deadline_us,
    input  logic            i_skip_allowed,
    input  logic            i_immediate_flag,
    input  logic [31:0]     i_cancel_target,
    output logic [1:0]      o_status,
    output logic [31:0]     o_assigned_id,
    output logic            o_was_merged,
    output logic [4:0]      o_live_depth,
    output logic [3:0]      o_out_display,
    output logic [2:0]      o_out_layer,
    output logic [31:0]     o_out_buffer,
    output logic [1:0]      o_out_priority,
    output logic [31:0]     o_out_frame,
    output logic [63:0]     o_out_deadline,
    output logic [31:0]     o_out_request_tag,
    output logic [1:0]      o_out_flags
);

    localparam int unsigned IW = $clog2(QUEUE_DEPTH);
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

    // Entries are registers; the scan reads one slot a cycle and a pop drops one
    // head slot a cycle.
    prq_pkg::t_entry r_q [QUEUE_DEPTH];
    prq_pkg::t_entry r_new, r_sel, r_res;
    logic [2:0]    r_mode;
    logic [31:0]   r_target;
    logic [CW-1:0] r_count, r_live, r_idx, r_pos, r_drop;
    logic [31:0]   r_next_id;
    logic          r_found, r_pos_set, r_full;
    logic [IW-1:0] r_hit;
    logic [1:0]    r_status;
    logic [31:0]   r_assigned_id;
    logic          r_was_merged;

    prq_pkg::t_entry w_cur;
    logic [IW-1:0]   w_idx;
    logic            w_live, w_match, w_scan_end;

    assign w_idx  = r_idx[IW-1:0];
    assign w_cur  = r_q[w_idx];
    assign w_live = !w_cur.cancelled;

    always_comb begin
        w_match = 1'b0;
        unique case (r_mode)
            prq_pkg::MODE_SUBMIT:
                w_match = w_live && w_cur.display == r_new.display &&
                          w_cur.layer == r_new.layer && w_cur.buffer == r_new.buffer &&
                          r_new.skip && w_cur.skip;
            prq_pkg::MODE_PEEK, prq_pkg::MODE_POP: w_match = w_live;
            prq_pkg::MODE_CANCEL: w_match = w_live && w_cur.id == r_target;
            default: w_match = 1'b0;
        endcase
    end

    // A refused submit and a flush need no pass over the entries.
    assign w_scan_end = (r_idx >= r_count) || r_found ||
                        r_mode == prq_pkg::MODE_FLUSH ||
                        (r_mode == prq_pkg::MODE_SUBMIT && r_full);

    assign o_sts.scan_done  = w_scan_end;
    assign o_sts.shift_done = (r_drop == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_live    <= '0;
            r_next_id <= 32'd1;
            r_mode    <= '0;
            r_drop    <= '0;
        end else if (i_cmd.load) begin
            r_mode          <= i_mode;
            r_target        <= i_cancel_target;
            r_new.id        <= r_next_id;
            r_new.buffer    <= i_buffer_handle;
            r_new.frame     <= i_frame_number;
            r_new.deadline  <= i_deadline_us;
            r_new.display   <= i_display_index;
            r_new.layer     <= i_layer_index;
            r_new.prio      <= i_prio_level;
            r_new.skip      <= i_skip_allowed;
            r_new.imm       <= i_immediate_flag;
            r_new.cancelled <= 1'b0;
            r_idx         <= '0;
            r_pos         <= r_count;
            r_found       <= 1'b0;
            r_pos_set     <= 1'b0;
            r_hit         <= '0;
            r_drop        <= '0;
            r_full        <= (r_count == CW'(QUEUE_DEPTH));
            r_sel         <= '0;
            r_res         <= '0;
            r_status      <= prq_pkg::ST_OK;
            r_assigned_id <= '0;
            r_was_merged  <= 1'b0;
        end else if (i_cmd.scan) begin
            if (!w_scan_end) begin
                r_idx <= r_idx + CW'(1);
                // Cancelled entries count for the insertion point too.
                if (r_mode == prq_pkg::MODE_SUBMIT && !r_pos_set &&
                    r_new.prio > w_cur.prio) begin
                    r_pos     <= r_idx;
                    r_pos_set <= 1'b1;
                end
                if (w_match) begin
                    r_found <= 1'b1;
                    r_hit   <= w_idx;
                    r_sel   <= w_cur;
                    // Every entry ahead of the first live one is cancelled and goes too.
                    if (r_mode == prq_pkg::MODE_POP) r_drop <= r_idx + CW'(1);
                end
            end
        end else if (i_cmd.shift) begin
            if (r_drop != '0) begin
                for (int j = 0; j < int'(QUEUE_DEPTH) - 1; j++)
                    r_q[j] <= r_q[j + 1];
                r_drop  <= r_drop - CW'(1);
                r_count <= r_count - CW'(1);
            end
        end else if (i_cmd.finish) begin
            unique case (r_mode)
                prq_pkg::MODE_SUBMIT: begin
                    if (r_full) begin
                        r_status <= prq_pkg::ST_FULL;
                    end else begin
                        r_next_id <= (r_next_id == 32'hFFFF_FFFF) ? 32'd1
                                                                   : r_next_id + 32'd1;
                        if (r_found) begin
                            r_assigned_id <= r_sel.id;
                            r_was_merged  <= 1'b1;
                        end else begin
                            r_assigned_id <= r_new.id;
                            for (int j = 0; j < int'(QUEUE_DEPTH); j++) begin
                                if (CW'(j) == r_pos)
                                    r_q[j] <= r_new;
                                else if (CW'(j) > r_pos && CW'(j) <= r_count)
                                    r_q[j] <= r_q[j - 1];
                            end
                            r_count <= r_count + CW'(1);
                            r_live  <= r_live + CW'(1);
                        end
                    end
                end
                prq_pkg::MODE_POP, prq_pkg::MODE_PEEK: begin
                    if (!r_found) begin
                        r_status <= prq_pkg::ST_EMPTY;
                        if (r_mode == prq_pkg::MODE_POP) r_count <= '0;
                    end else begin
                        r_res <= r_sel;
                        if (r_mode == prq_pkg::MODE_POP) r_live <= r_live - CW'(1);
                    end
                end
                prq_pkg::MODE_CANCEL: begin
                    if (r_found) begin
                        r_q[r_hit].cancelled <= 1'b1;
                        r_live <= r_live - CW'(1);
                    end else begin
                        r_status <= prq_pkg::ST_NONE;
                    end
                end
                prq_pkg::MODE_FLUSH: begin
                    r_count <= '0;
                    r_live  <= '0;
                end
                default: ;
            endcase
        end
    end

    assign o_status          = r_status;
    assign o_assigned_id     = r_assigned_id;
    assign o_was_merged      = r_was_merged;
    assign o_live_depth      = 5'(r_live);
    assign o_out_display     = r_res.display;
    assign o_out_layer       = r_res.layer;
    assign o_out_buffer      = r_res.buffer;
    assign o_out_priority    = r_res.prio;
    assign o_out_frame       = r_res.frame;
    assign o_out_deadline    = r_res.deadline;
    assign o_out_request_tag = r_res.id;
    assign o_out_flags       = {r_res.imm, r_res.skip};

endmodule

// ===== rtl/core/present_request_priority_queue_unit.sv =====
`timescale 1ns / 1ps
// After the input transfer the controller scans K slots, one a cycle (at most the
// stored count N), then a pop drops D head slots, one a cycle (at most N), and a
// finish step writes the result before it is offered.
// Items are handled one at a time, a new one taken the cycle after the result
// transfer.
// Reset (synchronous, active low) empties the queue and sets the next id to one.

module present_request_priority_queue_unit #(
    parameter int unsigned QUEUE_DEPTH = prq_pkg::QueueDepth
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_mode,
    input  logic [3:0]  i_display_index,
    input  logic [2:0]  i_layer_index,
    input  logic [31:0] i_buffer_handle,
    input  logic [1:0]  i_prio_level,
    input  logic [31:0] i_frame_number,
    input  logic [63:0] i_deadline_us,
    input  logic        i_skip_allowed,
    input  logic        i_immediate_flag,
    input  logic [31:0] i_cancel_target,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [31:0] o_assigned_id,
    output logic        o_was_merged,
    output logic [4:0]  o_live_depth,
    output logic [3:0]  o_out_display,
    output logic [2:0]  o_out_layer,
    output logic [31:0] o_out_buffer,
    output logic [1:0]  o_out_priority,
    output logic [31:0] o_out_frame,
    output logic [63:0] o_out_deadline,
    output logic [31:0] o_out_request_tag,
    output logic [1:0]  o_out_flags
);

    prq_pkg::t_cmd w_cmd;
    prq_pkg::t_sts w_sts;

    prq_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .o_out_valid, .i_out_ready,
        .i_sts(w_sts), .o_cmd(w_cmd)
    );

    prq_dp #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .o_sts(w_sts),
        .i_mode, .i_display_index, .i_layer_index, .i_buffer_handle, .i_prio_level,
        .i_frame_number, .i_deadline_us, .i_skip_allowed, .i_immediate_flag,
        .i_cancel_target, .o_status, .o_assigned_id, .o_was_merged, .o_live_depth,
        .o_out_display, .o_out_layer, .o_out_buffer, .o_out_priority, .o_out_frame,
        .o_out_deadline, .o_out_request_tag, .o_out_flags
    );

    a_no_accept_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready) else $error("input taken while a result waits");

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_live_depth <= 5'(QUEUE_DEPTH)) else $error("live depth beyond queue depth");

    a_merge_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_was_merged) |-> o_status == prq_pkg::ST_OK)
        else $error("merge reported with a failing status");

endmodule

// ===== tb/tb_present_request_priority_queue_unit.sv =====
`timescale 1ns / 1ps

module tb_present_request_priority_queue_unit;

    localparam int unsigned WatchdogLimit = 20000;

    typedef struct packed {
        logic [2:0]  mode;
        logic [3:0]  display;
        logic [2:0]  layer;
        logic [31:0] buffer;
        logic [1:0]  prio;
        logic [31:0] frame;
        logic [63:0] deadline;
        logic        skip;
        logic        imm;
        logic [31:0] target;
    } t_request;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] assigned_id;
        logic        was_merged;
        logic [4:0]  live_depth;
        logic [3:0]  display;
        logic [2:0]  layer;
        logic [31:0] buffer;
        logic [1:0]  prio;
        logic [31:0] frame;
        logic [63:0] deadline;
        logic [31:0] request_tag;
        logic [1:0]  flags;
    } t_answer;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic [2:0] i_mode = '0;
    logic [3:0] i_display_index = '0;
    logic [2:0] i_layer_index = '0;
    logic [31:0] i_buffer_handle = '0;
    logic [1:0] i_prio_level = '0;
    logic [31:0] i_frame_number = '0;
    logic [63:0] i_deadline_us = '0;
    logic i_skip_allowed = 1'b0;
    logic i_immediate_flag = 1'b0;
    logic [31:0] i_cancel_target = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic [1:0] o_status;
    logic [31:0] o_assigned_id;
    logic o_was_merged;
    logic [4:0] o_live_depth;
    logic [3:0] o_out_display;
    logic [2:0] o_out_layer;
    logic [31:0] o_out_buffer;
    logic [1:0] o_out_priority;
    logic [31:0] o_out_frame;
    logic [63:0] o_out_deadline;
    logic [31:0] o_out_request_tag;
    logic [1:0] o_out_flags;

    present_request_priority_queue_unit DUT (.*);

    always #1 i_clk = ~i_clk;

    t_request pending_requests[$];
    int unsigned request_phase[$];
    t_answer expected_answers[$];
    int unsigned phase = 0;
    int unsigned mismatches = 0;
    int unsigned quiet_cycles = 0;
    int unsigned submits_made = 0;

    // Shadow copy of the queue contents.
    prq_pkg::t_entry shadow_entries[prq_pkg::QueueDepth];
    int unsigned shadow_count = 0;
    logic [31:0] shadow_next_id = 32'd1;

    function automatic void fill_entry(inout t_answer a, input prq_pkg::t_entry e);
        a.display = e.display;
        a.layer = e.layer;
        a.buffer = e.buffer;
        a.prio = e.prio;
        a.frame = e.frame;
        a.deadline = e.deadline;
        a.request_tag = e.id;
        a.flags = {e.imm, e.skip};
    endfunction

    function automatic t_answer serve_request(t_request r);
        t_answer a;
        prq_pkg::t_entry e;
        int unsigned pos;
        int unsigned live;
        logic [31:0] id;
        logic merged;
        a = '0;
        a.status = prq_pkg::ST_OK;
        merged = 1'b0;
        case (r.mode)
            prq_pkg::MODE_SUBMIT: begin
                if (shadow_count >= prq_pkg::QueueDepth) begin
                    a.status = prq_pkg::ST_FULL;
                end else begin
                    id = shadow_next_id;
                    shadow_next_id = shadow_next_id + 1;
                    if (shadow_next_id == 0) shadow_next_id = 32'd1;
                    for (int i = 0; i < shadow_count && !merged; i++) begin
                        e = shadow_entries[i];
                        if (!e.cancelled && e.display == r.display && e.layer == r.layer
                                && e.buffer == r.buffer && r.skip && e.skip) begin
                            a.assigned_id = e.id;
                            a.was_merged = 1'b1;
                            merged = 1'b1;
                        end
                    end
                    if (!merged) begin
                        pos = shadow_count;
                        for (int i = shadow_count - 1; i >= 0; i--)
                            if (r.prio > shadow_entries[i].prio) pos = i;
                        for (int k = shadow_count; k > pos; k--)
                            shadow_entries[k] = shadow_entries[k - 1];
                        e.id = id;
                        e.buffer = r.buffer;
                        e.frame = r.frame;
                        e.deadline = r.deadline;
                        e.display = r.display;
                        e.layer = r.layer;
                        e.prio = r.prio;
                        e.skip = r.skip;
                        e.imm = r.imm;
                        e.cancelled = 1'b0;
                        shadow_entries[pos] = e;
                        shadow_count++;
                        a.assigned_id = id;
                    end
                end
            end
            prq_pkg::MODE_POP: begin
                while (shadow_count > 0 && shadow_entries[0].cancelled) begin
                    for (int j = 0; j + 1 < shadow_count; j++)
                        shadow_entries[j] = shadow_entries[j + 1];
                    shadow_count--;
                end
                if (shadow_count == 0) begin
                    a.status = prq_pkg::ST_EMPTY;
                end else begin
                    fill_entry(a, shadow_entries[0]);
                    for (int j = 0; j + 1 < shadow_count; j++)
                        shadow_entries[j] = shadow_entries[j + 1];
                    shadow_count--;
                end
            end
            prq_pkg::MODE_PEEK: begin
                a.status = prq_pkg::ST_EMPTY;
                for (int i = 0; i < shadow_count && a.status != prq_pkg::ST_OK; i++)
                    if (!shadow_entries[i].cancelled) begin
                        fill_entry(a, shadow_entries[i]);
                        a.status = prq_pkg::ST_OK;
                    end
            end
            prq_pkg::MODE_CANCEL: begin
                a.status = prq_pkg::ST_NONE;
                for (int i = 0; i < shadow_count && a.status != prq_pkg::ST_OK; i++)
                    if (shadow_entries[i].id == r.target && !shadow_entries[i].cancelled) begin
                        shadow_entries[i].cancelled = 1'b1;
                        a.status = prq_pkg::ST_OK;
                    end
            end
            prq_pkg::MODE_FLUSH: shadow_count = 0;
            default: ;
        endcase
        live = 0;
        for (int i = 0; i < shadow_count; i++)
            if (!shadow_entries[i].cancelled) live++;
        a.live_depth = live[4:0];
        return a;
    endfunction

    // Builds a request; a small pool of displays, layers and buffers makes merges likely.
    function automatic t_request make_request(logic [2:0] mode, bit wild);
        t_request r;
        int unsigned lo;
        r.mode = mode;
        r.display = wild ? 4'($urandom) : 4'($urandom_range(0, 1));
        r.layer = wild ? 3'($urandom) : 3'($urandom_range(0, 1));
        r.buffer = wild ? $urandom : 32'($urandom_range(0, 2));
        r.prio = 2'($urandom);
        r.frame = $urandom;
        r.deadline = {$urandom, $urandom};
        r.skip = ($urandom_range(0, 99) < 70);
        r.imm = 1'($urandom);
        lo = (submits_made > 20) ? submits_made - 20 : 1;
        if ($urandom_range(0, 9) == 0) r.target = $urandom;
        else r.target = $urandom_range(lo, submits_made + 1);
        if (mode == prq_pkg::MODE_SUBMIT) submits_made++;
        return r;
    endfunction

    task automatic add_request(t_request r, int unsigned ph);
        pending_requests.push_back(r);
        request_phase.push_back(ph);
    endtask

    function automatic logic [2:0] pick_mode(int unsigned submit_weight);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < submit_weight) return prq_pkg::MODE_SUBMIT;
        roll = $urandom_range(0, 99);
        if (roll < 40) return prq_pkg::MODE_POP;
        if (roll < 60) return prq_pkg::MODE_PEEK;
        if (roll < 92) return prq_pkg::MODE_CANCEL;
        if (roll < 96) return prq_pkg::MODE_FLUSH;
        return 3'($urandom_range(5, 7));
    endfunction

    initial begin
        t_request r;
        // Empty queue answers, then extremes, merges, a full queue and unknown modes.
        add_request(make_request(prq_pkg::MODE_POP, 0), 0);
        add_request(make_request(prq_pkg::MODE_PEEK, 0), 0);
        r = make_request(prq_pkg::MODE_CANCEL, 0);
        r.target = '1;
        add_request(r, 0);
        r = make_request(prq_pkg::MODE_SUBMIT, 0);
        r.display = '1; r.layer = '1; r.buffer = '1; r.prio = 2'd0; r.frame = '1;
        r.deadline = '1; r.skip = 1; r.imm = 1;
        add_request(r, 0);
        add_request(r, 0);
        r = make_request(prq_pkg::MODE_SUBMIT, 0);
        r.display = '0; r.layer = '0; r.buffer = '0; r.prio = 2'd3; r.frame = '0;
        r.deadline = '0; r.skip = 0; r.imm = 0;
        add_request(r, 0);
        add_request(make_request(prq_pkg::MODE_PEEK, 0), 0);
        for (int i = 0; i < 15; i++) add_request(make_request(prq_pkg::MODE_SUBMIT, 1), 0);
        r = make_request(prq_pkg::MODE_CANCEL, 0);
        r.target = 32'd2;
        add_request(r, 0);
        add_request(make_request(prq_pkg::MODE_POP, 0), 0);
        for (int m = 5; m < 8; m++) add_request(make_request(3'(m), 0), 0);
        add_request(make_request(prq_pkg::MODE_FLUSH, 0), 0);

        for (int i = 0; i < 1450; i++) begin
            int unsigned ph;
            int unsigned weight;
            ph = 1 + (i * 4) / 1450;
            // Alternate submit-heavy and drain-heavy stretches so depth sweeps its range.
            weight = ((i / 60) % 2 == 0) ? 75 : 30;
            add_request(make_request(pick_mode(weight), $urandom_range(0, 9) == 0), ph);
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_requests.size() == 0 && !i_in_valid && expected_answers.size() == 0);
        repeat (60) @(posedge i_clk);
        if (mismatches == 0 && expected_answers.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Phases: 0 and 4 no idling, 1 sender idle, 2 receiver stalls, 3 both.
    function automatic int unsigned sender_idle(int unsigned ph);
        return (ph == 1) ? 84 : (ph == 3) ? 29 : 0;
    endfunction

    function automatic int unsigned receiver_stall(int unsigned ph);
        return (ph == 2) ? 84 : (ph == 3) ? 29 : 0;
    endfunction

    always @(posedge i_clk) begin
        t_request r;
        logic next_valid;
        next_valid = i_in_valid;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                expected_answers.push_back(serve_request({i_mode, i_display_index,
                    i_layer_index, i_buffer_handle, i_prio_level, i_frame_number,
                    i_deadline_us, i_skip_allowed, i_immediate_flag, i_cancel_target}));
                next_valid = 1'b0;
            end
            if (!next_valid && pending_requests.size() > 0
                    && $urandom_range(0, 99) >= sender_idle(request_phase[0])) begin
                r = pending_requests.pop_front();
                phase <= request_phase.pop_front();
                i_mode <= r.mode;
                i_display_index <= r.display;
                i_layer_index <= r.layer;
                i_buffer_handle <= r.buffer;
                i_prio_level <= r.prio;
                i_frame_number <= r.frame;
                i_deadline_us <= r.deadline;
                i_skip_allowed <= r.skip;
                i_immediate_flag <= r.imm;
                i_cancel_target <= r.target;
                next_valid = 1'b1;
            end
            i_out_ready <= ($urandom_range(0, 99) >= receiver_stall(phase));
        end
        i_in_valid <= next_valid;
    end

    always @(posedge i_clk) begin
        t_answer seen;
        t_answer want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            seen = {o_status, o_assigned_id, o_was_merged, o_live_depth, o_out_display,
                o_out_layer, o_out_buffer, o_out_priority, o_out_frame, o_out_deadline,
                o_out_request_tag, o_out_flags};
            if (expected_answers.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result transfer: %p", seen);
            end else begin
                want = expected_answers.pop_front();
                if (seen.status !== want.status || seen.assigned_id !== want.assigned_id
                        || seen.was_merged !== want.was_merged
                        || seen.live_depth !== want.live_depth
                        || seen.display !== want.display || seen.layer !== want.layer
                        || seen.buffer !== want.buffer || seen.prio !== want.prio
                        || seen.frame !== want.frame || seen.deadline !== want.deadline
                        || seen.request_tag !== want.request_tag
                        || seen.flags !== want.flags) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch\n  expected %p\n  actual   %p", want, seen);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WatchdogLimit) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

// ===== files.f =====
rtl/core/prq_pkg.sv
rtl/core/prq_ctrl.sv
rtl/core/prq_dp.sv
rtl/core/present_request_priority_queue_unit.sv
tb/tb_present_request_priority_queue_unit.sv
